[rtl/kfuk_pkg.sv]
package kfuk_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned TDATA_W  = 72;

  localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DEQUEUE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COUNT    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_KEY_AT   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_VALUE_AT = 3'd5;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_DEQUEUE,
    OP_PEEK,
    OP_COUNT,
    OP_KEY_AT,
    OP_VALUE_AT,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
  } cmd_t;

  typedef struct packed {
    logic                    ok;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
    logic [OCC_W-1:0]        occ;
  } res_t;

endpackage

[rtl/keyed_fifo_unique_keys_core.sv]
// Keyed FIFO of up to DEPTH key/value entries with unique keys. Each input item carries
// an operation in tuser: insert, dequeue key, peek oldest value, count, key at position or
// value at position (position 1 is the oldest entry). Insert is refused when the queue is
// full or the key is already held; any refusal, empty queue, bad position or unknown
// operation gives ok low with key and value zero. Every item gives one result with the
// occupancy after the operation. Items enter a two-stage front (input register and a
// two-entry command queue), then execute one at a time against a single-read-port store.
// Count, refusals on a full queue and unknown operations finish in the execute unit without a
// store read, reads pass through a read state, and an insert into a non-empty queue first
// scans the stored keys for a duplicate, reading one stored key per cycle, before its result.
module keyed_fifo_unique_keys_core
  import kfuk_pkg::*;
#(
  parameter int unsigned DEPTH = 16
)
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // key_in[30:0], value_in[62:31], position[67:63], zero[71:68]
  input  logic [TDATA_W-1:0] s_axis_tdata,
  // mode[2:0]
  input  logic [MODE_W-1:0]  s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // key_out[30:0], value_out[62:31], occupancy[67:63], zero[71:68]
  output logic [TDATA_W-1:0] m_axis_tdata,
  // ok[0]
  output logic               m_axis_tuser
);

  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;
  res_t res;

  kfuk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .mode_i      (s_axis_tuser),
    .key_i       (s_axis_tdata[KEY_W-1:0]),
    .value_i     (s_axis_tdata[KEY_W+VAL_W-1:KEY_W]),
    .pos_i       (s_axis_tdata[KEY_W+VAL_W+POS_W-1:KEY_W+VAL_W]),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  kfuk_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  kfuk_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {(TDATA_W - KEY_W - VAL_W - OCC_W)'(0), res.occ, res.value, res.key};
  assign m_axis_tuser = res.ok;

endmodule

[rtl/kfuk_front.sv]
module kfuk_front
  import kfuk_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [MODE_W-1:0]       mode_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic [POS_W-1:0]        pos_i,
  output logic                    cmd_valid_o,
  input  logic                    cmd_ready_i,
  output cmd_t                    cmd_o
);

  logic valid_q;
  cmd_t cmd_q;
  op_e  op;

  always_comb begin
    unique case (mode_i)
      MODE_INSERT:   op = OP_INSERT;
      MODE_DEQUEUE:  op = OP_DEQUEUE;
      MODE_PEEK:     op = OP_PEEK;
      MODE_COUNT:    op = OP_COUNT;
      MODE_KEY_AT:   op = OP_KEY_AT;
      MODE_VALUE_AT: op = OP_VALUE_AT;
      default:       op = OP_NONE;
    endcase
  end

  assign ready_o     = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      cmd_q.op    <= op;
      cmd_q.key   <= key_i;
      cmd_q.value <= value_i;
      cmd_q.pos   <= pos_i;
    end
  end

endmodule

[rtl/kfuk_cmd_queue.sv]
module kfuk_cmd_queue
  import kfuk_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] fill_q;
  logic       push;
  logic       pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= push_cmd_i;
  end

endmodule

[rtl/kfuk_back.sv]
module kfuk_back
  import kfuk_pkg::*;
#(
  parameter int unsigned DEPTH = 16
)
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = ((AW > POS_W) ? AW : POS_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH
  } state_e;

  state_e                  state_q;
  cmd_t                    cmd_q;
  logic [CW-1:0]           cnt_q;
  logic [CW-1:0]           chk_q;
  logic [AW-1:0]           rd_ptr_q;
  logic [AW-1:0]           wr_ptr_q;
  logic [AW-1:0]           scan_ptr_q;
  logic                    res_vld_q;
  res_t                    res_q;

  logic [KEY_W-1:0]        key_mem [DEPTH];
  logic signed [VAL_W-1:0] val_mem [DEPTH];
  logic [KEY_W-1:0]        key_rd_q;
  logic signed [VAL_W-1:0] val_rd_q;

  logic [SW-1:0]           pos_sum;
  logic [SW-1:0]           pos_idx;
  logic [AW-1:0]           raddr;
  logic                    pop;
  logic                    head_found;
  logic                    busy_nxt;
  logic                    res_set;
  logic                    srch_hit;
  logic                    srch_last;
  logic                    ins_wr;
  logic [KEY_W-1:0]        wkey;
  logic signed [VAL_W-1:0] wval;
  logic [CW-1:0]           cnt_inc;
  logic [CW-1:0]           cnt_dec;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic res_t mk_res(input logic ok, input logic [KEY_W-1:0] k,
                                  input logic signed [VAL_W-1:0] v,
                                  input logic [CW-1:0] c);
    res_t r;
    r.ok    = ok;
    r.key   = k;
    r.value = v;
    r.occ   = OCC_W'(c);
    return r;
  endfunction

  assign cmd_ready_o = (state_q == ST_IDLE) && (!res_vld_q || res_ready_i);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;
  assign cnt_inc     = cnt_q + CW'(1);
  assign cnt_dec     = cnt_q - CW'(1);

  // ring index of a 1-based position, one wrap at most
  always_comb begin
    pos_sum = SW'(rd_ptr_q) + SW'(cmd_i.pos) - SW'(1);
    pos_idx = (pos_sum >= SW'(DEPTH)) ? pos_sum - SW'(DEPTH) : pos_sum;
  end

  always_comb begin
    unique case (cmd_i.op)
      OP_DEQUEUE, OP_PEEK:   head_found = (cnt_q != '0);
      OP_KEY_AT, OP_VALUE_AT:
        head_found = (cmd_i.pos != '0) && (SW'(cmd_i.pos) <= SW'(cnt_q));
      default:               head_found = 1'b0;
    endcase
  end

  always_comb begin
    if (state_q == ST_SEARCH) begin
      raddr = scan_ptr_q;
    end else if (cmd_i.op == OP_KEY_AT || cmd_i.op == OP_VALUE_AT) begin
      raddr = AW'(pos_idx);
    end else begin
      raddr = rd_ptr_q;
    end
  end

  assign srch_hit  = (key_rd_q == cmd_q.key);
  assign srch_last = (chk_q == cnt_dec);
  assign ins_wr    = (state_q == ST_IDLE && pop && cmd_i.op == OP_INSERT && cnt_q == '0)
                  || (state_q == ST_SEARCH && !srch_hit && srch_last);
  assign wkey      = (state_q == ST_IDLE) ? cmd_i.key : cmd_q.key;
  assign wval      = (state_q == ST_IDLE) ? cmd_i.value : cmd_q.value;

  // item needs a read or a key scan before its result
  assign busy_nxt  = head_found
                  || (cmd_i.op == OP_INSERT && cnt_q != '0 && cnt_q != CW'(DEPTH));
  assign res_set   = (state_q == ST_IDLE && pop && !busy_nxt)
                  || (state_q == ST_READ)
                  || (state_q == ST_SEARCH && (srch_hit || srch_last));

  always_ff @(posedge clk_i) begin
    if (ins_wr) begin
      key_mem[wr_ptr_q] <= wkey;
      val_mem[wr_ptr_q] <= wval;
    end
    key_rd_q <= key_mem[raddr];
    val_rd_q <= val_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_set) begin
      res_vld_q <= 1'b1;
    end else if (res_ready_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (pop) begin
            cmd_q      <= cmd_i;
            scan_ptr_q <= nxt(rd_ptr_q);
            chk_q      <= '0;
            unique case (cmd_i.op)
              OP_INSERT: begin
                if (cnt_q == CW'(DEPTH)) begin
                  res_q <= mk_res(1'b0, '0, '0, cnt_q);
                end else if (cnt_q != '0) begin
                  state_q <= ST_SEARCH;
                end
              end
              OP_COUNT: begin
                res_q <= mk_res(1'b1, '0, '0, cnt_q);
              end
              OP_NONE: begin
                res_q <= mk_res(1'b0, '0, '0, cnt_q);
              end
              default: begin
                if (head_found) begin
                  state_q <= ST_READ;
                end else begin
                  res_q <= mk_res(1'b0, '0, '0, cnt_q);
                end
              end
            endcase
          end
        end
        ST_READ: begin
          state_q <= ST_IDLE;
          unique case (cmd_q.op)
            OP_DEQUEUE: begin
              rd_ptr_q <= nxt(rd_ptr_q);
              cnt_q    <= cnt_dec;
              res_q    <= mk_res(1'b1, key_rd_q, '0, cnt_dec);
            end
            OP_PEEK, OP_VALUE_AT: res_q <= mk_res(1'b1, '0, val_rd_q, cnt_q);
            OP_KEY_AT:            res_q <= mk_res(1'b1, key_rd_q, '0, cnt_q);
            default:              res_q <= mk_res(1'b0, '0, '0, cnt_q);
          endcase
        end
        ST_SEARCH: begin
          if (srch_hit) begin
            res_q   <= mk_res(1'b0, '0, '0, cnt_q);
            state_q <= ST_IDLE;
          end else if (!srch_last) begin
            chk_q      <= chk_q + CW'(1);
            scan_ptr_q <= nxt(scan_ptr_q);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (ins_wr) begin
        wr_ptr_q <= nxt(wr_ptr_q);
        cnt_q    <= cnt_inc;
        res_q    <= mk_res(1'b1, '0, '0, cnt_inc);
        state_q  <= ST_IDLE;
      end
    end
  end

endmodule

[rtl/kfuk_checker.sv]
module kfuk_checker
  import kfuk_pkg::*;
#(
  parameter int unsigned DEPTH = 16
)
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_refusal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[KEY_W+VAL_W-1:0] == '0)
    else $error("refused result carries data");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (DEPTH >= 32)
      || (m_axis_tdata[KEY_W+VAL_W+OCC_W-1:KEY_W+VAL_W] <= OCC_W'(DEPTH)))
    else $error("occupancy above depth");

endmodule

bind keyed_fifo_unique_keys_core kfuk_checker #(
  .DEPTH (DEPTH)
) u_kfuk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
